// ===== design/bde_pkg.sv =====
// Package for the button debounce and event detector.
// Holds register indexes, reset values, event bit positions and shared types.
// No dependencies.
`default_nettype none

package bde_pkg;

    // Widths fixed by the register map and the word layout
    localparam int CFG_BITS      = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int EV_BITS       = 8;
    localparam int TIME_BITS_DEF = 16;
    localparam int S_TDATA_BITS  = 16;
    localparam int M_TDATA_BITS  = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LONG         = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_VERY_LONG    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DBL_PRESS    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DBL_RELEASE  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_DBL_MIN      = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_HIGH  = 3'd6;

    // Register reset values
    localparam logic [CFG_BITS-1:0] DEBOUNCE_RST    = 16'd20;
    localparam logic [CFG_BITS-1:0] LONG_RST        = 16'd1000;
    localparam logic [CFG_BITS-1:0] VERY_LONG_RST   = 16'd3000;
    localparam logic [CFG_BITS-1:0] DBL_PRESS_RST   = 16'd400;
    localparam logic [CFG_BITS-1:0] DBL_RELEASE_RST = 16'd400;
    localparam logic [CFG_BITS-1:0] DBL_MIN_RST     = 16'd20;

    // Event flag bit positions
    localparam int EV_PRESS   = 0;
    localparam int EV_RELEASE = 1;
    localparam int EV_LONG    = 2;
    localparam int EV_VLONG   = 3;
    localparam int EV_CLICK   = 4;
    localparam int EV_DOUBLE  = 5;
    localparam int EV_LCLICK  = 6;
    localparam int EV_VLCLICK = 7;

    // Double press phases
    typedef enum logic [1:0] {
        DBL_IDLE   = 2'd0,
        DBL_FIRST  = 2'd1,
        DBL_GAP    = 2'd2,
        DBL_SECOND = 2'd3
    } dbl_phase_t;

    // Hold tracker report towards the top level
    typedef struct packed {
        logic [EV_BITS-1:0] set;
        logic               release_seen;
    } hold_evt_t;

endpackage

`default_nettype wire

// ===== design/bde_debounce.sv =====
// Debouncer: tracks the raw level and its stable time, updates the pressed state.
// Depends on bde_pkg.
`default_nettype none

module bde_debounce #(
    parameter int TIME_BITS = bde_pkg::TIME_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic                         lvl,
    input  wire logic                         active_high,
    input  wire logic [bde_pkg::CFG_BITS-1:0] debounce_ms,
    input  wire logic [TIME_BITS-1:0]         t_now,
    output logic                              pressed_next,
    output logic                              done_next
);

    localparam int CMP_BITS = (TIME_BITS > bde_pkg::CFG_BITS) ? TIME_BITS : bde_pkg::CFG_BITS;

    logic                 raw_last_reg, raw_last_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    logic                 done_reg;
    logic                 pressed_reg;
    logic [TIME_BITS-1:0] elapsed;

    assign elapsed = t_now - start_reg;

    // Restart the stable timer on a change, accept the level once it has held
    always_comb begin
        raw_last_next = raw_last_reg;
        start_next    = start_reg;
        done_next     = done_reg;
        pressed_next  = pressed_reg;
        if (lvl != raw_last_reg) begin
            start_next    = t_now;
            done_next     = 1'b0;
            raw_last_next = lvl;
        end else if (!done_reg &&
                     (CMP_BITS'(elapsed) > CMP_BITS'(debounce_ms))) begin
            done_next    = 1'b1;
            pressed_next = (lvl == active_high);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_last_reg <= 1'b0;
            start_reg    <= '0;
            done_reg     <= 1'b0;
            pressed_reg  <= 1'b0;
        end else if (en) begin
            raw_last_reg <= raw_last_next;
            start_reg    <= start_next;
            done_reg     <= done_next;
            pressed_reg  <= pressed_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/bde_hold.sv =====
// Hold tracker: press, release, long, very long and the click family by hold time.
// Depends on bde_pkg.
`default_nettype none

module bde_hold #(
    parameter int TIME_BITS = bde_pkg::TIME_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic                         restart,
    input  wire logic                         pressed,
    input  wire logic [bde_pkg::CFG_BITS-1:0] long_ms,
    input  wire logic [bde_pkg::CFG_BITS-1:0] very_long_ms,
    input  wire logic [TIME_BITS-1:0]         t_now,
    output bde_pkg::hold_evt_t                evt
);

    localparam int CMP_BITS = (TIME_BITS > bde_pkg::CFG_BITS) ? TIME_BITS : bde_pkg::CFG_BITS;

    logic                 was_pressed_reg, was_pressed_next;
    logic                 timing_reg, timing_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    logic                 timing_cur;
    logic [TIME_BITS-1:0] start_cur;
    logic [TIME_BITS-1:0] held_ticks;
    logic [CMP_BITS-1:0]  held;
    logic [CMP_BITS-1:0]  long_lim;
    logic [CMP_BITS-1:0]  vlong_lim;

    // Restart drops hold timing before this tick is looked at
    assign timing_cur = restart ? 1'b0 : timing_reg;
    assign start_cur  = restart ? '0 : start_reg;
    // Wrap at the timer width before widening for the compare
    assign held_ticks = t_now - start_cur;
    assign held       = CMP_BITS'(held_ticks);
    assign long_lim   = CMP_BITS'(long_ms);
    assign vlong_lim  = CMP_BITS'(very_long_ms);

    always_comb begin
        was_pressed_next = was_pressed_reg;
        timing_next      = timing_cur;
        start_next       = start_cur;
        evt              = '0;
        if (was_pressed_reg) begin
            if (pressed) begin
                // Still held: flag long and very long once the time is past
                if (timing_cur) begin
                    evt.set[bde_pkg::EV_LONG]  = held > long_lim;
                    evt.set[bde_pkg::EV_VLONG] = held > vlong_lim;
                end
            end else begin
                // Released: classify the hold
                evt.set[bde_pkg::EV_RELEASE] = 1'b1;
                evt.release_seen             = 1'b1;
                if (timing_cur) begin
                    if (held < long_lim) begin
                        evt.set[bde_pkg::EV_CLICK] = 1'b1;
                    end else if (held < vlong_lim) begin
                        evt.set[bde_pkg::EV_LCLICK] = 1'b1;
                    end else begin
                        evt.set[bde_pkg::EV_VLCLICK] = 1'b1;
                    end
                end
                timing_next      = 1'b0;
                was_pressed_next = 1'b0;
            end
        end else if (pressed) begin
            evt.set[bde_pkg::EV_PRESS] = 1'b1;
            timing_next                = 1'b1;
            start_next                 = t_now;
            was_pressed_next           = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            was_pressed_reg <= 1'b0;
            timing_reg      <= 1'b0;
            start_reg       <= '0;
        end else if (en) begin
            was_pressed_reg <= was_pressed_next;
            timing_reg      <= timing_next;
            start_reg       <= start_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/bde_double.sv =====
// Double press detector: four-phase machine with press, gap and minimum windows.
// Depends on bde_pkg.
`default_nettype none

module bde_double #(
    parameter int TIME_BITS = bde_pkg::TIME_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic                         restart,
    input  wire logic                         pressed,
    input  wire logic [bde_pkg::CFG_BITS-1:0] press_max_ms,
    input  wire logic [bde_pkg::CFG_BITS-1:0] release_max_ms,
    input  wire logic [bde_pkg::CFG_BITS-1:0] min_ms,
    input  wire logic [TIME_BITS-1:0]         t_now,
    output logic                              double_seen,
    output logic                              busy_next
);

    localparam int CMP_BITS = (TIME_BITS > bde_pkg::CFG_BITS) ? TIME_BITS : bde_pkg::CFG_BITS;

    bde_pkg::dbl_phase_t  phase_reg, phase_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    logic [TIME_BITS-1:0] start_cur;
    logic [TIME_BITS-1:0] phase_ticks;
    logic [CMP_BITS-1:0]  d;
    logic                 over_press;
    logic                 over_release;
    logic                 past_min;

    assign start_cur    = restart ? '0 : start_reg;
    // Wrap at the timer width before widening for the compare
    assign phase_ticks  = t_now - start_cur;
    assign d            = CMP_BITS'(phase_ticks);
    assign over_press   = d > CMP_BITS'(press_max_ms);
    assign over_release = d > CMP_BITS'(release_max_ms);
    assign past_min     = d > CMP_BITS'(min_ms);

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            bde_pkg::DBL_IDLE: begin
                if (pressed) phase_next = bde_pkg::DBL_FIRST;
            end
            bde_pkg::DBL_FIRST: begin
                if (over_press) phase_next = bde_pkg::DBL_IDLE;
                else if (!pressed && past_min) phase_next = bde_pkg::DBL_GAP;
            end
            bde_pkg::DBL_GAP: begin
                if (over_release) phase_next = bde_pkg::DBL_IDLE;
                else if (pressed && past_min) phase_next = bde_pkg::DBL_SECOND;
            end
            bde_pkg::DBL_SECOND: begin
                if (over_press) phase_next = bde_pkg::DBL_IDLE;
                else if (!pressed && past_min) phase_next = bde_pkg::DBL_IDLE;
            end
            default: phase_next = bde_pkg::DBL_IDLE;
        endcase
    end

    // Phase timer and double event
    always_comb begin
        start_next  = start_cur;
        double_seen = 1'b0;
        case (phase_reg)
            bde_pkg::DBL_IDLE: begin
                if (pressed) start_next = t_now;
            end
            bde_pkg::DBL_FIRST: begin
                if (!over_press && !pressed && past_min) start_next = t_now;
            end
            bde_pkg::DBL_GAP: begin
                if (!over_release && pressed && past_min) start_next = t_now;
            end
            bde_pkg::DBL_SECOND: begin
                if (!over_press && !pressed && past_min) begin
                    start_next  = '0;
                    double_seen = 1'b1;
                end
            end
            default: start_next = start_cur;
        endcase
    end

    assign busy_next = (phase_next != bde_pkg::DBL_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= bde_pkg::DBL_IDLE;
            start_reg <= '0;
        end else if (en) begin
            phase_reg <= phase_next;
            start_reg <= start_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/button_debounce_event_detector_top.sv =====
// Button debounce and event detector, top level: tick counter, registers,
// sticky flags and the result register. Uses bde_pkg, bde_debounce, bde_hold, bde_double.
//
// Each input word is one millisecond tick carrying the raw pin level, a clear
// mask and a restart bit; each tick gives exactly one result word with the
// debounced pressed state, a debouncing flag, the eight event flags (press,
// release, long once per hold, very long, click, double, long click, very
// long click) as held before the clear mask, and a double-press busy flag.
// Per tick, all timer compares and the small phase machines sit
// between the state registers and a single result register, so one word is
// taken every cycle while the result side keeps up, and the input stalls only
// while a result is waiting and m_tready is low. Registers must be written through
// the cfg port only while no tick is in flight; the block does not enforce this.
`default_nettype none

module button_debounce_event_detector_top #(
    parameter int TIME_BITS = bde_pkg::TIME_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Configuration writes
    input  wire logic                             cfg_wr_en,
    input  wire logic [bde_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [bde_pkg::CFG_BITS-1:0]     cfg_data,
    // Tick words in
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // bit 0 pin_level, bits 8:1 clear_mask, bit 9 restart, bits 15:10 zero
    input  wire logic [bde_pkg::S_TDATA_BITS-1:0] s_tdata,
    // Result words out
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // bit 0 pressed, bit 1 debouncing, bits 9:2 event_flags, bit 10 double_busy,
    // bits 15:11 zero
    output logic [bde_pkg::M_TDATA_BITS-1:0]      m_tdata
);

    localparam int EVB = bde_pkg::EV_BITS;

    // Configuration registers
    logic [bde_pkg::CFG_BITS-1:0] debounce_ms_reg;
    logic [bde_pkg::CFG_BITS-1:0] long_ms_reg;
    logic [bde_pkg::CFG_BITS-1:0] very_long_ms_reg;
    logic [bde_pkg::CFG_BITS-1:0] dbl_press_ms_reg;
    logic [bde_pkg::CFG_BITS-1:0] dbl_release_ms_reg;
    logic [bde_pkg::CFG_BITS-1:0] dbl_min_ms_reg;
    logic                         active_high_reg;

    // Tick state
    logic [TIME_BITS-1:0] time_reg;
    logic [TIME_BITS-1:0] t_now;
    logic [EVB-1:0]       sticky_reg, sticky_next;
    logic                 long_rep_reg, long_rep_next;

    // Output register
    logic                            m_tvalid_reg;
    logic [bde_pkg::M_TDATA_BITS-1:0] m_tdata_reg, m_tdata_next;

    logic           accept;
    logic           pin_level;
    logic [EVB-1:0] clear_mask;
    logic           restart;
    logic           pressed_next;
    logic           done_next;
    logic           double_seen;
    logic           busy_next;
    logic [EVB-1:0] sticky_cur;
    logic [EVB-1:0] sticky_all;
    logic [EVB-1:0] report;
    logic           long_rep_mid;

    bde_pkg::hold_evt_t hold_evt;

    // Unpack the input word
    assign pin_level  = s_tdata[0];
    assign clear_mask = s_tdata[EVB:1];
    assign restart    = s_tdata[EVB+1];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign t_now    = time_reg + TIME_BITS'(1);

    bde_debounce #(.TIME_BITS(TIME_BITS)) u_debounce (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (accept),
        .lvl          (pin_level),
        .active_high  (active_high_reg),
        .debounce_ms  (debounce_ms_reg),
        .t_now        (t_now),
        .pressed_next (pressed_next),
        .done_next    (done_next)
    );

    bde_hold #(.TIME_BITS(TIME_BITS)) u_hold (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (accept),
        .restart      (restart),
        .pressed      (pressed_next),
        .long_ms      (long_ms_reg),
        .very_long_ms (very_long_ms_reg),
        .t_now        (t_now),
        .evt          (hold_evt)
    );

    bde_double #(.TIME_BITS(TIME_BITS)) u_double (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (accept),
        .restart        (restart),
        .pressed        (pressed_next),
        .press_max_ms   (dbl_press_ms_reg),
        .release_max_ms (dbl_release_ms_reg),
        .min_ms         (dbl_min_ms_reg),
        .t_now          (t_now),
        .double_seen    (double_seen),
        .busy_next      (busy_next)
    );

    // Merge new events, show long once per hold, then drop the cleared flags
    always_comb begin
        sticky_cur   = restart ? '0 : sticky_reg;
        sticky_all   = sticky_cur | hold_evt.set;
        sticky_all[bde_pkg::EV_DOUBLE] = sticky_all[bde_pkg::EV_DOUBLE] | double_seen;
        long_rep_mid  = hold_evt.release_seen ? 1'b0 : long_rep_reg;
        report        = sticky_all;
        long_rep_next = long_rep_mid;
        if (sticky_all[bde_pkg::EV_LONG]) begin
            if (long_rep_mid) begin
                report[bde_pkg::EV_LONG] = 1'b0;
            end else begin
                long_rep_next = 1'b1;
            end
        end
        sticky_next  = sticky_all & ~clear_mask;
        m_tdata_next = {5'd0, busy_next, report, !done_next, pressed_next};
    end

    // Tick state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg     <= '0;
            sticky_reg   <= '0;
            long_rep_reg <= 1'b0;
        end else if (accept) begin
            time_reg     <= t_now;
            sticky_reg   <= sticky_next;
            long_rep_reg <= long_rep_next;
        end
    end

    // Result word: load on accept, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ms_reg    <= bde_pkg::DEBOUNCE_RST;
            long_ms_reg        <= bde_pkg::LONG_RST;
            very_long_ms_reg   <= bde_pkg::VERY_LONG_RST;
            dbl_press_ms_reg   <= bde_pkg::DBL_PRESS_RST;
            dbl_release_ms_reg <= bde_pkg::DBL_RELEASE_RST;
            dbl_min_ms_reg     <= bde_pkg::DBL_MIN_RST;
            active_high_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bde_pkg::REG_DEBOUNCE:    debounce_ms_reg    <= cfg_data;
                bde_pkg::REG_LONG:        long_ms_reg        <= cfg_data;
                bde_pkg::REG_VERY_LONG:   very_long_ms_reg   <= cfg_data;
                bde_pkg::REG_DBL_PRESS:   dbl_press_ms_reg   <= cfg_data;
                bde_pkg::REG_DBL_RELEASE: dbl_release_ms_reg <= cfg_data;
                bde_pkg::REG_DBL_MIN:     dbl_min_ms_reg     <= cfg_data;
                bde_pkg::REG_ACTIVE_HIGH: active_high_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire
